@@ rtl/core/vmps_pkg.sv @@
package vmps_pkg;

    localparam int OVERDRIVE_MS_DEF = 20;
    localparam int BRAKE_MS_DEF     = 20;
    localparam int MAX_RUN_MS_DEF   = 15000;

    // requests longer than the overdrive phase and up to this length end with a brake phase
    localparam int SPLIT_LIMIT = 100;

    localparam int DUTY_W = 13;
    localparam int LEFT_W = 14;
    localparam int AMP_W  = 7;

    localparam logic [DUTY_W-1:0] DUTY_OVER = 13'd4200;
    localparam logic [DUTY_W-1:0] DUTY_BASE = 13'd3200;
    localparam logic [DUTY_W-1:0] DUTY_OFF  = 13'd0;
    localparam logic [AMP_W-1:0]  AMP_RESET = 7'd50;
    localparam logic [LEFT_W-1:0] LEFT_MAX  = 14'h3FFF;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_OVER  = 2'd1;
    localparam logic [1:0] PH_HOLD  = 2'd2;
    localparam logic [1:0] PH_BRAKE = 2'd3;

    localparam logic FUNC_RUN  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] duration_ms;
    } t_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_word;
        logic              drive_on;
        logic              busy_res;
        logic [1:0]        phase_now;
        logic [LEFT_W-1:0] time_left_ms;
        logic              rejected;
    } t_out;

endpackage

@@ rtl/core/vibration_motor_phase_sequencer.sv @@
// Vibration motor phase sequencer.
// Input channel (i_in_valid / o_in_stall / i_in_data) carries run commands and
// one-millisecond ticks; every accepted beat yields exactly one result beat on
// the output channel (o_out_valid / i_out_stall / o_out_data) with the duty
// word, drive enable, busy flag, phase, time left and reject flag.
// The config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the hold
// amplitude in percent; it is always ready and should be written while idle.
// From input acceptance, an item passes through the input register and then the
// state update into the result register before the result is valid.
// Throughput is one item per cycle while the output is not stalled.
// A stall on the output holds the result register; one more beat waits in the
// input register, after which o_in_stall rises until the output drains.
// Reset (synchronous, active low) returns the sequencer to idle with zero duty,
// amplitude 50, and empties both registers.
module vibration_motor_phase_sequencer #(
    parameter int OVERDRIVE_MS = vmps_pkg::OVERDRIVE_MS_DEF,
    parameter int BRAKE_MS     = vmps_pkg::BRAKE_MS_DEF,
    parameter int MAX_RUN_MS   = vmps_pkg::MAX_RUN_MS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  vmps_pkg::t_in              i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output vmps_pkg::t_out             o_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_valid,
    input  logic [vmps_pkg::AMP_W-1:0] i_cfg_data,
    output logic                       o_cfg_ready
);

    logic           out_ready;
    logic           take;
    vmps_pkg::t_in  item;
    vmps_pkg::t_out res;

    vmps_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .i_next_ready (out_ready),
        .o_take       (take),
        .o_item       (item)
    );

    vmps_seq #(
        .OVERDRIVE_MS (OVERDRIVE_MS),
        .BRAKE_MS     (BRAKE_MS),
        .MAX_RUN_MS   (MAX_RUN_MS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_take      (take),
        .i_item      (item),
        .o_res       (res)
    );

    vmps_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_res       (res),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ rtl/core/vmps_in_stage.sv @@
module vmps_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  vmps_pkg::t_in i_in_data,
    output logic          o_in_stall,
    input  logic          i_next_ready,
    output logic          o_take,
    output vmps_pkg::t_in o_item
);

    logic          r_valid;
    vmps_pkg::t_in r_item;

    assign o_take     = r_valid && i_next_ready;
    assign o_in_stall = r_valid && !i_next_ready;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_in_data;
        end
    end

endmodule

@@ rtl/core/vmps_seq.sv @@
module vmps_seq #(
    parameter int OVERDRIVE_MS = vmps_pkg::OVERDRIVE_MS_DEF,
    parameter int BRAKE_MS     = vmps_pkg::BRAKE_MS_DEF,
    parameter int MAX_RUN_MS   = vmps_pkg::MAX_RUN_MS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [vmps_pkg::AMP_W-1:0]   i_cfg_data,
    output logic                         o_cfg_ready,
    input  logic                         i_take,
    input  vmps_pkg::t_in                i_item,
    output vmps_pkg::t_out               o_res
);

    localparam int CW = $clog2(MAX_RUN_MS + 1);
    localparam int BW = $clog2(BRAKE_MS + 1);

    localparam logic [16:0] K_OD    = 17'(OVERDRIVE_MS);
    localparam logic [16:0] K_BR    = 17'(BRAKE_MS);
    localparam logic [16:0] K_ODBR  = 17'(OVERDRIVE_MS + BRAKE_MS);
    localparam logic [16:0] K_SPLIT = 17'(vmps_pkg::SPLIT_LIMIT);
    localparam logic [16:0] K_LEFT  = 17'(vmps_pkg::LEFT_MAX);
    localparam logic [15:0] K_MAX   = 16'(MAX_RUN_MS);

    logic [vmps_pkg::AMP_W-1:0]  r_amp;
    logic [1:0]                  r_phase, n_phase;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [CW-1:0]               r_hold, n_hold;
    logic [BW-1:0]               r_brake, n_brake;
    logic [vmps_pkg::DUTY_W-1:0] r_duty, n_duty;

    logic [vmps_pkg::DUTY_W-1:0] hold_duty;
    logic [16:0]                 req;
    logic [16:0]                 first, hold_len, brake_len;
    logic [CW-1:0]               cnt_dec;
    logic                        rej;
    logic [16:0]                 cnt_wide;

    assign o_cfg_ready = 1'b1;

    // 10*amp + base, wrapping at the duty width
    assign hold_duty = vmps_pkg::DUTY_W'({r_amp, 3'b000}) + vmps_pkg::DUTY_W'({r_amp, 1'b0})
                     + vmps_pkg::DUTY_BASE;

    always_comb begin
        req = {1'b0, (i_item.duration_ms > K_MAX) ? K_MAX : i_item.duration_ms};
        if (req <= K_OD) begin
            first     = req;
            hold_len  = 17'd0;
            brake_len = 17'd0;
        end else if (req <= K_ODBR) begin
            first     = K_OD;
            hold_len  = 17'd0;
            brake_len = req - K_OD;
        end else if (req <= K_SPLIT) begin
            first     = K_OD;
            hold_len  = req - K_ODBR;
            brake_len = K_BR;
        end else begin
            first     = K_OD;
            hold_len  = req - K_OD;
            brake_len = 17'd0;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_hold  = r_hold;
        n_brake = r_brake;
        n_duty  = r_duty;
        rej     = 1'b0;
        cnt_dec = (r_cnt != '0) ? r_cnt - CW'(1) : '0;

        if (i_take) begin
            if (i_item.func == vmps_pkg::FUNC_TICK) begin
                if (r_phase != vmps_pkg::PH_IDLE) begin
                    n_cnt = cnt_dec;
                    if (cnt_dec == '0) begin
                        // walk through any empty phases in the same tick
                        unique case (r_phase)
                            vmps_pkg::PH_OVER: begin
                                if (r_hold != '0) begin
                                    n_phase = vmps_pkg::PH_HOLD;
                                    n_duty  = hold_duty;
                                    n_cnt   = r_hold;
                                end else if (r_brake != '0) begin
                                    n_phase = vmps_pkg::PH_BRAKE;
                                    n_duty  = vmps_pkg::DUTY_OFF;
                                    n_cnt   = CW'(r_brake);
                                end else begin
                                    n_phase = vmps_pkg::PH_IDLE;
                                    n_duty  = vmps_pkg::DUTY_OFF;
                                end
                            end
                            vmps_pkg::PH_HOLD: begin
                                n_duty = vmps_pkg::DUTY_OFF;
                                if (r_brake != '0) begin
                                    n_phase = vmps_pkg::PH_BRAKE;
                                    n_cnt   = CW'(r_brake);
                                end else begin
                                    n_phase = vmps_pkg::PH_IDLE;
                                end
                            end
                            default: begin
                                n_phase = vmps_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
            end else if (i_item.duration_ms == 16'd0) begin
                n_phase = vmps_pkg::PH_IDLE;
            end else if (r_phase != vmps_pkg::PH_IDLE) begin
                rej = 1'b1;
            end else begin
                n_phase = vmps_pkg::PH_OVER;
                n_duty  = vmps_pkg::DUTY_OVER;
                n_cnt   = CW'(first);
                n_hold  = CW'(hold_len);
                n_brake = BW'(brake_len);
            end
        end

        if (n_phase == vmps_pkg::PH_IDLE) begin
            n_cnt = '0;
        end
    end

    assign cnt_wide = 17'(n_cnt);

    always_comb begin
        o_res.duty_word    = n_duty;
        o_res.drive_on     = (n_phase != vmps_pkg::PH_IDLE);
        o_res.busy_res     = (n_phase != vmps_pkg::PH_IDLE);
        o_res.phase_now    = n_phase;
        o_res.time_left_ms = (cnt_wide > K_LEFT) ? vmps_pkg::LEFT_MAX
                                                 : vmps_pkg::LEFT_W'(cnt_wide);
        o_res.rejected     = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp   <= vmps_pkg::AMP_RESET;
            r_phase <= vmps_pkg::PH_IDLE;
            r_cnt   <= '0;
            r_hold  <= '0;
            r_brake <= '0;
            r_duty  <= vmps_pkg::DUTY_OFF;
        end else begin
            if (i_cfg_valid) begin
                r_amp <= i_cfg_data;
            end
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_hold  <= n_hold;
            r_brake <= n_brake;
            r_duty  <= n_duty;
        end
    end

endmodule

@@ rtl/core/vmps_out_stage.sv @@
module vmps_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  vmps_pkg::t_out i_res,
    output logic           o_ready,
    output logic           o_out_valid,
    output vmps_pkg::t_out o_out_data,
    input  logic           i_out_stall
);

    logic           r_valid;
    vmps_pkg::t_out r_data;

    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_take;
        end
    end

    // hold the beat while stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_take) begin
            r_data <= i_res;
        end
    end

endmodule

@@ rtl/core/vmps_checker.sv @@
module vmps_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input vmps_pkg::t_in              i_in_data,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input vmps_pkg::t_out             o_out_data,
    input logic                       i_out_stall,
    input logic                       i_cfg_valid,
    input logic [vmps_pkg::AMP_W-1:0] i_cfg_data,
    input logic                       o_cfg_ready
);

    logic unused_in;

    assign unused_in = i_in_valid ^ (^i_in_data) ^ o_in_stall ^ i_cfg_valid ^ (^i_cfg_data)
                     ^ o_cfg_ready;

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output beat dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("output beat changed while stalled");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.drive_on == o_out_data.busy_res) &&
                        (o_out_data.busy_res == (o_out_data.phase_now != vmps_pkg::PH_IDLE)))
        else $error("drive, busy and phase disagree");

    a_idle_no_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.phase_now == vmps_pkg::PH_IDLE
            |-> o_out_data.time_left_ms == '0)
        else $error("time left while idle");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.rejected |-> o_out_data.busy_res)
        else $error("reject reported while idle");

endmodule

bind vibration_motor_phase_sequencer vmps_checker u_chk (.*);
